[rtl/election_heartbeat_timer_table_macros.svh]
// Assertion macros for the election heartbeat timer table.
// Used by election_heartbeat_timer_table.sv; expects clk and rst_n in scope.
`ifndef ELECTION_HEARTBEAT_TIMER_TABLE_MACROS_SVH
`define ELECTION_HEARTBEAT_TIMER_TABLE_MACROS_SVH

`ifndef SYNTH
`define EHT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("eht assertion failed");
`define EHT_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("eht forbidden condition");
`else
`define EHT_ASSERT(lbl, prop)
`define EHT_ASSERT_NEVER(lbl, cond)
`endif

`endif

[rtl/eht_pkg.sv]
// Shared types and codes for the election heartbeat timer table.
// No dependencies.
`default_nettype none
package eht_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LK_RD,
        ST_LK_CK,
        ST_ACT,
        ST_SH_RD,
        ST_SH_WR,
        ST_PL_RD,
        ST_PL_CK,
        ST_ER_RD,
        ST_ER_CK,
        ST_EM_RD,
        ST_EM_LD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_NOTE     = 3'd2,
        OP_POLL     = 3'd3,
        OP_REJECT   = 3'd4,
        OP_COMPLETE = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_INVALID   = 3'd1,
        STS_EXISTS    = 3'd2,
        STS_EXHAUSTED = 3'd3,
        STS_NOTFOUND  = 3'd4
    } status_t;

    localparam logic [1:0] ROLE_LEADER = 2'd2;

    localparam logic [1:0] REG_HEARTBEAT  = 2'd0;
    localparam logic [1:0] REG_GROUP_LIM  = 2'd1;
    localparam logic [1:0] REG_POLL_LIM   = 2'd2;

    localparam logic [31:0] HEARTBEAT_RST = 32'd1000;
    localparam logic [6:0]  GROUP_LIM_RST = 7'd64;
    localparam logic [6:0]  POLL_LIM_RST  = 7'd8;

endpackage
`default_nettype wire

[rtl/eht_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module eht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/election_heartbeat_timer_table.sv]
// Ordered table of per-group election/heartbeat timers, one entry RAM and one fire queue RAM.
// A valid non-poll item runs a lookup scan (LK_RD/LK_CK), a poll a poll scan (PL_RD/PL_CK),
// a remove that hits also a shift (SH_RD/SH_WR); every item ends with an earliest-deadline
// scan (ER_RD/ER_CK), and a poll with fired entries emits them one beat each
// (EM_RD/EM_LD/OUT). One item at a time (s_tready only in ST_IDLE); beats wait on m_tready.
// Reset: async active low; clears count and control state, loads register defaults.
`default_nettype none
`include "election_heartbeat_timer_table_macros.svh"
module election_heartbeat_timer_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_BITS   = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // stream in
    input  wire logic s_tvalid,
    output logic      s_tready,
    // group tag, action tag, action generation, node id, role, now time,
    // election time, zero pad
    input  wire logic [((226 + 2*TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  wire logic [2:0] s_tuser,
    // stream out
    output logic m_tvalid,
    input  wire logic m_tready,
    // status, fired_group, fired_generation, group_total, earliest_valid,
    // earliest_deadline, zero pad
    output logic [((132 + $clog2(TABLE_DEPTH + 1) + TIME_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // fired_valid, fired_kind
    output logic [1:0] m_tuser,
    // last_result
    output logic m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import eht_pkg::*;

    localparam int IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int LW     = (CW > 7) ? CW : 7;
    localparam int SW     = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam int OUT_B  = 132 + CW + TIME_BITS;
    localparam int OUT_W  = ((OUT_B + 7) / 8) * 8;
    localparam int EW     = 130 + TIME_BITS;
    localparam int DL_LO  = 64;
    localparam int GEN_LO = 64 + TIME_BITS;
    localparam int FL_LO  = 128 + TIME_BITS;
    localparam int FQW    = 129;
    localparam int NOW_LO = 226;
    localparam int EL_LO  = 226 + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TMAX  = {TIME_BITS{1'b1}};
    localparam logic [CW-1:0]        DEPTH_C = CW'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [2:0]           op_reg, op_next;
    logic [63:0]          gid_reg, gid_next;
    logic [63:0]          agid_reg, agid_next;
    logic [63:0]          agen_reg, agen_next;
    logic [31:0]          node_reg, node_next;
    logic [1:0]           role_reg, role_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] elect_reg, elect_next;

    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        fire_n_reg, fire_n_next;
    logic [CW-1:0]        emit_k_reg, emit_k_next;
    logic                 hit_reg, hit_next;
    logic [CW-1:0]        hit_idx_reg, hit_idx_next;
    logic [EW-1:0]        ent_reg, ent_next;
    logic [2:0]           status_reg, status_next;
    logic                 have_reg, have_next;
    logic [TIME_BITS-1:0] best_reg, best_next;

    logic [2:0]           o_status_reg, o_status_next;
    logic                 o_fv_reg, o_fv_next;
    logic [63:0]          o_group_reg, o_group_next;
    logic [63:0]          o_gen_reg, o_gen_next;
    logic                 o_kind_reg, o_kind_next;
    logic                 o_last_reg, o_last_next;

    logic [31:0]          hb_reg;
    logic [6:0]           glim_reg;
    logic [6:0]           plim_reg;

    // entry RAM
    logic          e_we, e_re;
    logic [IW-1:0] e_waddr, e_raddr;
    logic [EW-1:0] e_wdata, e_rdata;
    // fire queue RAM
    logic          f_we, f_re;
    logic [IW-1:0] f_waddr, f_raddr;
    logic [FQW-1:0] f_wdata, f_rdata;

    eht_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    eht_ram #(.WIDTH(FQW), .DEPTH(TABLE_DEPTH)) u_fire_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // read-data fields
    logic [63:0]          rd_tag, rd_gen, ent_gen;
    logic [TIME_BITS-1:0] rd_dl;
    logic                 rd_flight, ent_flight, ent_leader;
    assign rd_tag     = e_rdata[63:0];
    assign rd_dl      = e_rdata[GEN_LO-1:DL_LO];
    assign rd_gen     = e_rdata[FL_LO-1:GEN_LO];
    assign rd_flight  = e_rdata[FL_LO+1];
    assign ent_gen    = ent_reg[FL_LO-1:GEN_LO];
    assign ent_flight = ent_reg[FL_LO+1];
    assign ent_leader = ent_reg[FL_LO];

    // arming values
    logic                 is_leader, obs_ok, full, in_accept, out_beat;
    logic [SW-1:0]        hb_sum;
    logic [TIME_BITS-1:0] arm_dl;
    logic [63:0]          lk_key;
    assign is_leader = (role_reg == ROLE_LEADER);
    assign hb_sum    = SW'(now_reg) + SW'(hb_reg);
    assign arm_dl    = !is_leader ? elect_reg
                     : (hb_sum > SW'(TMAX)) ? TMAX : hb_sum[TIME_BITS-1:0];
    assign obs_ok    = (gid_reg != 64'd0) && (node_reg != 32'd0)
                     && (is_leader || (elect_reg > now_reg));
    assign full      = (LW'(count_reg) >= LW'(glim_reg)) || (count_reg >= DEPTH_C);
    assign lk_key    = ((op_reg == OP_REJECT) || (op_reg == OP_COMPLETE)) ? agid_reg : gid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_beat  = m_tvalid && m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser == OP_POLL)
                        state_next = ST_PL_RD;
                    else if (s_tuser > OP_COMPLETE)
                        state_next = ST_ER_RD;
                    else
                        state_next = ST_LK_RD;
                end
            end
            ST_LK_RD: state_next = (idx_reg >= count_reg) ? ST_ACT : ST_LK_CK;
            ST_LK_CK: state_next = (rd_tag == lk_key) ? ST_ACT : ST_LK_RD;
            ST_ACT:   state_next = (op_reg == OP_REMOVE && hit_reg) ? ST_SH_RD : ST_ER_RD;
            ST_SH_RD: state_next = (idx_reg + CW'(1) >= count_reg) ? ST_ER_RD : ST_SH_WR;
            ST_SH_WR: state_next = ST_SH_RD;
            ST_PL_RD:
            begin
                if (idx_reg >= count_reg || LW'(fire_n_reg) >= LW'(plim_reg))
                    state_next = ST_ER_RD;
                else
                    state_next = ST_PL_CK;
            end
            ST_PL_CK: state_next = ST_PL_RD;
            ST_ER_RD:
            begin
                if (idx_reg < count_reg)
                    state_next = ST_ER_CK;
                else if (op_reg == OP_POLL && fire_n_reg != '0)
                    state_next = ST_EM_RD;
                else
                    state_next = ST_OUT;
            end
            ST_ER_CK: state_next = ST_ER_RD;
            ST_EM_RD: state_next = ST_EM_LD;
            ST_EM_LD: state_next = ST_OUT;
            ST_OUT:
            begin
                if (m_tready)
                    state_next = o_last_reg ? ST_IDLE : ST_EM_RD;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next       = op_reg;
        gid_next      = gid_reg;
        agid_next     = agid_reg;
        agen_next     = agen_reg;
        node_next     = node_reg;
        role_next     = role_reg;
        now_next      = now_reg;
        elect_next    = elect_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        fire_n_next   = fire_n_reg;
        emit_k_next   = emit_k_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        ent_next      = ent_reg;
        status_next   = status_reg;
        have_next     = have_reg;
        best_next     = best_reg;
        o_status_next = o_status_reg;
        o_fv_next     = o_fv_reg;
        o_group_next  = o_group_reg;
        o_gen_next    = o_gen_reg;
        o_kind_next   = o_kind_reg;
        o_last_next   = o_last_reg;
        e_we    = 1'b0;
        e_waddr = idx_reg[IW-1:0];
        e_wdata = ent_reg;
        e_re    = 1'b0;
        e_raddr = idx_reg[IW-1:0];
        f_we    = 1'b0;
        f_waddr = fire_n_reg[IW-1:0];
        f_wdata = {ent_leader, ent_gen, ent_reg[63:0]};
        f_re    = 1'b0;
        f_raddr = emit_k_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = s_tuser;
                    gid_next    = s_tdata[63:0];
                    agid_next   = s_tdata[127:64];
                    agen_next   = s_tdata[191:128];
                    node_next   = s_tdata[223:192];
                    role_next   = s_tdata[225:224];
                    now_next    = s_tdata[NOW_LO+TIME_BITS-1:NOW_LO];
                    elect_next  = s_tdata[EL_LO+TIME_BITS-1:EL_LO];
                    idx_next    = '0;
                    fire_n_next = '0;
                    hit_next    = 1'b0;
                    have_next   = 1'b0;
                    best_next   = '0;
                    status_next = (s_tuser > OP_COMPLETE) ? STS_INVALID : STS_OK;
                end
            end
            ST_LK_RD:
            begin
                e_re = (idx_reg < count_reg);
            end
            ST_LK_CK:
            begin
                if (rd_tag == lk_key)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    ent_next     = e_rdata;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_ACT:
            begin
                e_waddr  = hit_idx_reg[IW-1:0];
                idx_next = '0;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (hit_reg)
                            status_next = STS_EXISTS;
                        else if (full)
                            status_next = STS_EXHAUSTED;
                        else if (!obs_ok)
                            status_next = STS_INVALID;
                        else
                        begin
                            status_next = STS_OK;
                            e_we        = 1'b1;
                            e_waddr     = count_reg[IW-1:0];
                            e_wdata     = {1'b0, is_leader, 64'd1, arm_dl, gid_reg};
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        status_next = hit_reg ? STS_OK : STS_NOTFOUND;
                        if (hit_reg)
                            idx_next = hit_idx_reg;
                    end
                    OP_NOTE:
                    begin
                        if (!hit_reg)
                            status_next = STS_NOTFOUND;
                        else if (!obs_ok)
                            status_next = STS_INVALID;
                        else if (ent_gen == 64'hFFFF_FFFF_FFFF_FFFF)
                            status_next = STS_EXHAUSTED;
                        else
                        begin
                            status_next = STS_OK;
                            e_we        = 1'b1;
                            e_wdata     = {1'b0, is_leader, ent_gen + 64'd1, arm_dl, gid_reg};
                        end
                    end
                    OP_REJECT:
                    begin
                        if (!hit_reg)
                            status_next = STS_NOTFOUND;
                        else if (!ent_flight || ent_gen != agen_reg)
                            status_next = STS_INVALID;
                        else
                        begin
                            status_next = STS_OK;
                            e_we        = 1'b1;
                            e_wdata     = {1'b0, ent_reg[FL_LO-1+1:0]};
                        end
                    end
                    OP_COMPLETE:
                    begin
                        if (!hit_reg)
                            status_next = STS_NOTFOUND;
                        else if (!ent_flight || ent_gen != agen_reg || gid_reg != agid_reg)
                            status_next = STS_INVALID;
                        else if (!obs_ok)
                            status_next = STS_INVALID;
                        else if (ent_gen == 64'hFFFF_FFFF_FFFF_FFFF)
                            status_next = STS_EXHAUSTED;
                        else
                        begin
                            status_next = STS_OK;
                            e_we        = 1'b1;
                            e_wdata     = {1'b0, is_leader, ent_gen + 64'd1, arm_dl, gid_reg};
                        end
                    end
                    default: status_next = STS_INVALID;
                endcase
            end
            ST_SH_RD:
            begin
                // pull entry idx+1 down into idx; last step drops the count
                if (idx_reg + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    idx_next   = '0;
                end
                else
                begin
                    e_re    = 1'b1;
                    e_raddr = IW'(idx_reg + CW'(1));
                end
            end
            ST_SH_WR:
            begin
                e_we     = 1'b1;
                e_wdata  = e_rdata;
                idx_next = idx_reg + CW'(1);
            end
            ST_PL_RD:
            begin
                if (idx_reg >= count_reg || LW'(fire_n_reg) >= LW'(plim_reg))
                    idx_next = '0;
                else
                    e_re = 1'b1;
            end
            ST_PL_CK:
            begin
                if (!rd_flight && now_reg >= rd_dl)
                begin
                    e_we        = 1'b1;
                    e_wdata     = {1'b1, e_rdata[FL_LO:0]};
                    f_we        = 1'b1;
                    f_wdata     = {e_rdata[FL_LO], rd_gen, rd_tag};
                    fire_n_next = fire_n_reg + CW'(1);
                end
                idx_next = idx_reg + CW'(1);
            end
            ST_ER_RD:
            begin
                if (idx_reg < count_reg)
                    e_re = 1'b1;
                else
                begin
                    emit_k_next   = '0;
                    o_status_next = status_reg;
                    o_fv_next     = 1'b0;
                    o_group_next  = '0;
                    o_gen_next    = '0;
                    o_kind_next   = 1'b0;
                    o_last_next   = 1'b1;
                end
            end
            ST_ER_CK:
            begin
                if (!rd_flight && (!have_reg || rd_dl < best_reg))
                begin
                    have_next = 1'b1;
                    best_next = rd_dl;
                end
                idx_next = idx_reg + CW'(1);
            end
            ST_EM_RD:
            begin
                f_re = 1'b1;
            end
            ST_EM_LD:
            begin
                o_status_next = STS_OK;
                o_fv_next     = 1'b1;
                o_group_next  = f_rdata[63:0];
                o_gen_next    = f_rdata[127:64];
                o_kind_next   = f_rdata[128];
                o_last_next   = (emit_k_reg + CW'(1) == fire_n_reg);
            end
            ST_OUT:
            begin
                if (m_tready)
                    emit_k_next = emit_k_reg + CW'(1);
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            fire_n_reg <= '0;
            hb_reg     <= HEARTBEAT_RST;
            glim_reg   <= GROUP_LIM_RST;
            plim_reg   <= POLL_LIM_RST;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            fire_n_reg <= fire_n_next;
            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    REG_HEARTBEAT: hb_reg   <= pwdata;
                    REG_GROUP_LIM: glim_reg <= pwdata[6:0];
                    REG_POLL_LIM:  plim_reg <= pwdata[6:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        gid_reg      <= gid_next;
        agid_reg     <= agid_next;
        agen_reg     <= agen_next;
        node_reg     <= node_next;
        role_reg     <= role_next;
        now_reg      <= now_next;
        elect_reg    <= elect_next;
        idx_reg      <= idx_next;
        emit_k_reg   <= emit_k_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        ent_reg      <= ent_next;
        status_reg   <= status_next;
        have_reg     <= have_next;
        best_reg     <= best_next;
        o_status_reg <= o_status_next;
        o_fv_reg     <= o_fv_next;
        o_group_reg  <= o_group_next;
        o_gen_reg    <= o_gen_next;
        o_kind_reg   <= o_kind_next;
        o_last_reg   <= o_last_next;
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_HEARTBEAT: prdata = hb_reg;
            REG_GROUP_LIM: prdata = {25'd0, glim_reg};
            REG_POLL_LIM:  prdata = {25'd0, plim_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_kind_reg, o_fv_reg};
    assign m_tdata  = OUT_W'({(have_reg ? best_reg : {TIME_BITS{1'b0}}), have_reg, count_reg,
                              o_gen_reg, o_group_reg, o_status_reg});

    `EHT_ASSERT(a_count_bound, count_reg <= DEPTH_C)
    `EHT_ASSERT(a_fire_bound, (state_reg != ST_IDLE) |-> (LW'(fire_n_reg) <= LW'(plim_reg)))
    `EHT_ASSERT(a_last_frees, (out_beat && m_tlast) |=> s_tready)
    `EHT_ASSERT_NEVER(a_count_moves,
        (count_reg != $past(count_reg)) && ($past(state_reg) != ST_ACT)
        && ($past(state_reg) != ST_SH_RD))
    `EHT_ASSERT_NEVER(a_emit_overrun, m_tvalid && o_fv_reg && (emit_k_reg >= fire_n_reg))

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the election heartbeat timer table: drives mixed directed and
// random operations over the stream port, checks every output beat on a scoreboard.
// Depends on eht_pkg and election_heartbeat_timer_table in rtl/.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import eht_pkg::*;

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        status_t     status;
        bit          fired_valid;
        bit [63:0]   fired_group;
        bit [63:0]   fired_generation;
        bit          fired_kind;
        bit          last_result;
        bit [6:0]    group_total;
        bit          earliest_valid;
        bit [47:0]   earliest_deadline;
    } timer_result_t;

    class timer_table_checker;
        bit [63:0] tags[64];
        bit [47:0] deadlines[64];
        bit [63:0] generations[64];
        bit        leader[64];
        bit        busy[64];
        int        used;
        bit [31:0] heartbeat;
        int        group_cap;
        int        fire_cap;
        int        errors;
        timer_result_t awaited[$];

        function new();
            used = 0;
            heartbeat = HEARTBEAT_RST;
            group_cap = GROUP_LIM_RST;
            fire_cap = POLL_LIM_RST;
            errors = 0;
        endfunction

        function int find_tag(bit [63:0] t);
            for (int i = 0; i < used; i++)
                if (tags[i] == t)
                    return i;
            return -1;
        endfunction

        function bit observation_ok(bit [63:0] t, bit [31:0] node, bit [1:0] role,
                                    bit [47:0] now, bit [47:0] elect);
            if (t == 0 || node == 0)
                return 0;
            return role == ROLE_LEADER || elect > now;
        endfunction

        function status_t rearm(int idx, bit [63:0] t, bit [1:0] role, bit [47:0] now,
                                bit [47:0] elect, bit bump);
            bit [63:0] sum;
            if (bump && generations[idx] == '1)
                return STS_EXHAUSTED;
            tags[idx] = t;
            if (role == ROLE_LEADER)
            begin
                sum = {16'b0, now} + {32'b0, heartbeat};
                deadlines[idx] = (sum > {16'b0, TIME_MAX}) ? TIME_MAX : sum[47:0];
                leader[idx] = 1;
            end
            else
            begin
                deadlines[idx] = elect;
                leader[idx] = 0;
            end
            busy[idx] = 0;
            if (bump)
                generations[idx]++;
            return STS_OK;
        endfunction

        // works out the beats one accepted input produces and queues them
        function void apply_item(logic [2:0] op, bit [63:0] gid, bit [63:0] agid,
                                 bit [63:0] agen, bit [31:0] node, bit [1:0] role,
                                 bit [47:0] now, bit [47:0] elect);
            timer_result_t beats[$];
            timer_result_t r;
            status_t st;
            int idx;
            bit have;
            bit [47:0] best;
            r = '{STS_OK, 0, 0, 0, 0, 0, 0, 0, 0};
            st = STS_INVALID;
            idx = (op == OP_REJECT || op == OP_COMPLETE) ? find_tag(agid) : find_tag(gid);
            case (op)
                OP_ADD:
                    if (idx >= 0)
                        st = STS_EXISTS;
                    else if (used >= group_cap || used >= 64)
                        st = STS_EXHAUSTED;
                    else if (!observation_ok(gid, node, role, now, elect))
                        st = STS_INVALID;
                    else
                    begin
                        generations[used] = 1;
                        st = rearm(used, gid, role, now, elect, 0);
                        used++;
                    end
                OP_REMOVE:
                    if (idx < 0)
                        st = STS_NOTFOUND;
                    else
                    begin
                        for (int i = idx; i + 1 < used; i++)
                        begin
                            tags[i] = tags[i + 1];
                            deadlines[i] = deadlines[i + 1];
                            generations[i] = generations[i + 1];
                            leader[i] = leader[i + 1];
                            busy[i] = busy[i + 1];
                        end
                        used--;
                        st = STS_OK;
                    end
                OP_NOTE:
                    if (idx < 0)
                        st = STS_NOTFOUND;
                    else if (!observation_ok(gid, node, role, now, elect))
                        st = STS_INVALID;
                    else
                        st = rearm(idx, gid, role, now, elect, 1);
                OP_POLL:
                    for (int i = 0; i < used; i++)
                    begin
                        if (beats.size() >= fire_cap)
                            break;
                        if (busy[i] || now < deadlines[i])
                            continue;
                        busy[i] = 1;
                        r.fired_valid = 1;
                        r.fired_group = tags[i];
                        r.fired_generation = generations[i];
                        r.fired_kind = leader[i];
                        beats = {beats, r};
                    end
                OP_REJECT:
                    if (idx < 0)
                        st = STS_NOTFOUND;
                    else if (!busy[idx] || generations[idx] != agen)
                        st = STS_INVALID;
                    else
                    begin
                        busy[idx] = 0;
                        st = STS_OK;
                    end
                OP_COMPLETE:
                    if (idx < 0)
                        st = STS_NOTFOUND;
                    else if (!busy[idx] || generations[idx] != agen || gid != agid)
                        st = STS_INVALID;
                    else if (!observation_ok(gid, node, role, now, elect))
                        st = STS_INVALID;
                    else
                        st = rearm(idx, gid, role, now, elect, 1);
                default:
                    st = STS_INVALID;
            endcase
            if (beats.size() == 0)
            begin
                r = '{STS_OK, 0, 0, 0, 0, 0, 0, 0, 0};
                r.status = (op == OP_POLL) ? STS_OK : st;
                beats = {beats, r};
            end
            have = 0;
            best = 0;
            for (int i = 0; i < used; i++)
                if (!busy[i] && (!have || deadlines[i] < best))
                begin
                    best = deadlines[i];
                    have = 1;
                end
            foreach (beats[k])
            begin
                beats[k].last_result = (k == beats.size() - 1);
                beats[k].group_total = 7'(used);
                beats[k].earliest_valid = have;
                beats[k].earliest_deadline = best;
                awaited = {awaited, beats[k]};
            end
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(timer_result_t got);
            timer_result_t want;
            if (awaited.size() == 0)
            begin
                $error("output beat with nothing awaited");
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("status", want.status, got.status);
            compare("fired_valid", want.fired_valid, got.fired_valid);
            compare("fired_group", want.fired_group, got.fired_group);
            compare("fired_generation", want.fired_generation, got.fired_generation);
            compare("fired_kind", want.fired_kind, got.fired_kind);
            compare("last_result", want.last_result, got.last_result);
            compare("group_total", want.group_total, got.group_total);
            compare("earliest_valid", want.earliest_valid, got.earliest_valid);
            compare("earliest_deadline", want.earliest_deadline, got.earliest_deadline);
        endfunction

        // random in-flight entry, for well-formed reject and complete
        function bit pick_busy(output bit [63:0] t, output bit [63:0] g);
            int hits[$];
            int k;
            for (int i = 0; i < used; i++)
                if (busy[i])
                    hits = {hits, i};
            if (hits.size() == 0)
                return 0;
            k = hits[$urandom_range(0, hits.size() - 1)];
            t = tags[k];
            g = generations[k];
            return 1;
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // group tag, action tag, action generation, node id, role, now time,
    // election time, zero pad
    logic [327:0] s_tdata = '0;
    // opcode
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // status, fired_group, fired_generation, group_total, earliest_valid,
    // earliest_deadline, zero pad
    logic [191:0] m_tdata;
    // fired_valid, fired_kind
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    election_heartbeat_timer_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    timer_table_checker tracker = new();
    bit        gaps_on = 1'b0;
    int        ready_hold = 0;
    int        quiet_cycles = 0;
    bit [47:0] clock_now = 48'd100;

    always #5 clk = ~clk;

    // sink side: random backpressure, beat checking, stall watchdog
    always @(posedge clk)
    begin
        timer_result_t got;
        if (rst_n)
        begin
            if (ready_hold > 0)
            begin
                ready_hold--;
                if (ready_hold == 0)
                    m_tready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                ready_hold = $urandom_range(1, 17);
            end
            else
                m_tready <= 1'b1;

            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[2:0]);
                got.fired_group = m_tdata[66:3];
                got.fired_generation = m_tdata[130:67];
                got.group_total = m_tdata[137:131];
                got.earliest_valid = m_tdata[138];
                got.earliest_deadline = m_tdata[186:139];
                got.fired_valid = m_tuser[0];
                got.fired_kind = m_tuser[1];
                got.last_result = m_tlast;
                tracker.check_beat(got);
            end

            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_op(logic [2:0] op, bit [63:0] gid, bit [63:0] agid, bit [63:0] agen,
                           bit [31:0] node, bit [1:0] role, bit [47:0] now, bit [47:0] elect);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'b0, elect, now, role, node, agen, agid, gid};
        do @(posedge clk); while (!s_tready);
        tracker.apply_item(op, gid, agid, agen, node, role, now, elect);
    endtask

    // sender holds off until every awaited beat is back and the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, bit [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEARTBEAT: tracker.heartbeat = value;
            REG_GROUP_LIM: tracker.group_cap = value[6:0];
            default:       tracker.fire_cap = value[6:0];
        endcase
    endtask

    function automatic bit [63:0] pick_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 64'd0;
        if (r < 10)
            return {$urandom, $urandom};
        return 64'($urandom_range(1, 12));
    endfunction

    function automatic bit [31:0] pick_node();
        return ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
    endfunction

    function automatic bit [1:0] pick_role();
        return ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    endfunction

    task automatic random_item();
        int r;
        bit [63:0] t;
        bit [63:0] g;
        bit [47:0] el;
        r = $urandom_range(0, 99);
        // mostly a future election deadline, now and then a stale one
        el = clock_now + (($urandom_range(0, 9) == 0) ? 48'd0 : 48'($urandom_range(1, 300)));
        if (r < 20)
            send_op(OP_ADD, pick_tag(), {$urandom, $urandom}, {$urandom, $urandom},
                    pick_node(), pick_role(), clock_now, el);
        else if (r < 30)
            send_op(OP_REMOVE, pick_tag(), 0, 0, $urandom, pick_role(), clock_now, el);
        else if (r < 44)
            send_op(OP_NOTE, pick_tag(), 0, 0, pick_node(), pick_role(), clock_now, el);
        else if (r < 62)
        begin
            clock_now += 48'($urandom_range(0, 160));
            send_op(OP_POLL, pick_tag(), 0, 0, $urandom, pick_role(), clock_now, el);
        end
        else if (r < 88)
        begin
            if (!tracker.pick_busy(t, g))
            begin
                t = pick_tag();
                g = 64'($urandom_range(1, 3));
            end
            if ($urandom_range(0, 7) == 0)
                g ^= 64'd1;
            if (r < 74)
                send_op(OP_REJECT, pick_tag(), t, g, $urandom, pick_role(), clock_now, el);
            else
                send_op(OP_COMPLETE, ($urandom_range(0, 9) == 0) ? pick_tag() : t, t, g,
                        pick_node(), pick_role(), clock_now, el);
        end
        else
            send_op(3'($urandom_range(0, 7)), {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, $urandom, 2'($urandom_range(0, 3)),
                    48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    endtask

    initial
    begin
        bit [31:0] beat_gap[8] = '{1, 32'hFFFF_FFFF, 50, 200, 7, 1000, 32'hFFFF_FFFF, 300};
        int        group_set[8] = '{1, 64, 5, 64, 3, 20, 64, 64};
        int        fire_set[8] = '{1, 64, 2, 3, 64, 8, 1, 8};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: add checks, role three, re-arm, misses, polls, stale actions, bad opcodes
        send_op(OP_ADD, 1, 0, 0, 5, 0, 100, 150);
        send_op(OP_ADD, 2, 0, 0, 32'hFFFF_FFFF, ROLE_LEADER, 100, 0);
        send_op(OP_ADD, 1, 0, 0, 5, 0, 100, 150);
        send_op(OP_ADD, 0, 0, 0, 5, 0, 100, 150);
        send_op(OP_ADD, 3, 0, 0, 0, 0, 100, 150);
        send_op(OP_ADD, 3, 0, 0, 5, 1, 100, 100);
        send_op(OP_ADD, 3, 0, 0, 5, 3, 100, 400);
        send_op(OP_NOTE, 1, 0, 0, 9, ROLE_LEADER, 120, 0);
        send_op(OP_NOTE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 9, 0, 120, 500);
        send_op(OP_POLL, 0, 0, 0, 0, 0, 130, 0);
        send_op(OP_POLL, 0, 0, 0, 0, 0, TIME_MAX, 0);
        send_op(OP_REJECT, 0, 2, 7, 0, 0, 0, 0);
        send_op(OP_REJECT, 0, 2, 1, 0, 0, 0, 0);
        send_op(OP_REJECT, 0, 9, 1, 0, 0, 0, 0);
        send_op(OP_COMPLETE, 3, 1, 2, 5, 0, 200, 900);
        send_op(OP_COMPLETE, 1, 1, 2, 5, 0, 200, 900);
        send_op(OP_COMPLETE, 3, 3, 1, 5, ROLE_LEADER, TIME_MAX - 10, 0);
        send_op(OP_REMOVE, 2, 0, 0, 0, 0, 0, 0);
        send_op(OP_REMOVE, 2, 0, 0, 0, 0, 0, 0);
        send_op(3'd6, 1, 1, 1, 1, 0, 0, 0);
        send_op(3'd7, 1, 1, 1, 1, 0, 0, 0);
        send_op(OP_REMOVE, 1, 0, 0, 0, 0, 0, 0);
        send_op(OP_REMOVE, 3, 0, 0, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            reg_write(REG_HEARTBEAT, beat_gap[ph]);
            reg_write(REG_GROUP_LIM, group_set[ph]);
            reg_write(REG_POLL_LIM, fire_set[ph]);
            // one phase runs near the top of the time range for saturation and wrap
            clock_now = (ph == 6) ? TIME_MAX - 48'd3000 : 48'($urandom_range(100, 5000));
            gaps_on = (ph != 7) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 55; n++)
            begin
                random_item();
                if (ph == 3 && n == 27)
                    drain();
            end
            drain();
        end
        gaps_on = 1'b0;

        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
